// ----- design/rau_pkg.sv -----
// Package with the command codes, order codes, sequencer states and widths of the rational arithmetic unit.
package rau_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_t;

  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
endpackage

// ----- design/rational_arithmetic_unit_top.sv -----
// Top level of the rational arithmetic unit: cross products, GCD reduction, sign handling.
// W = 2*OPERAND_BITS+1 is the magnitude width. One shared multiplier forms the three products
// in the states S_MUL1, S_MUL2 and S_SUM. A binary GCD then runs on the magnitudes, and a
// shift-subtract divider, one quotient bit per cycle, makes the two exact divisions by the
// GCD, each giving a W-bit quotient. Errors and unused commands go from S_MUL1 straight to
// S_DONE, and a zero result from S_SUM to S_DONE. The result sits in its own output
// register, so the next item can be accepted while a result waits. Only a finished result
// that finds that register still full holds the sequencer. A new item can be accepted in
// the cycle after a result moves into the output register.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int OPERAND_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              command,
  input  logic signed [15:0]      a_num,
  input  logic signed [15:0]      a_den,
  input  logic signed [15:0]      b_num,
  input  logic signed [15:0]      b_den,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [NUM_W-1:0] result_num,
  output logic [DEN_W-1:0]        result_den,
  output logic [1:0]              order,
  output logic                    error
);
  localparam int OB = OPERAND_BITS;
  localparam int PW = 2 * OB;
  localparam int MW = PW + 1;
  localparam int CW = $clog2(MW + 1) + 1;
  localparam int IW = (OB > 16) ? OB : 16;

  state_t state, state_next;

  logic [2:0]         cmd;
  logic signed [OB-1:0] an, ad, bn, bd;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p1, p2;
  logic               neg, neg_next;
  logic [MW-1:0]      mn, md, u, v, q, rem, g;
  logic [MW-1:0]      mn_next, md_next, u_next, v_next, q_next, rem_next, g_next;
  logic [CW-1:0]      cnt, cnt_next, sh, sh_next;
  logic signed [OB-1:0] ma, mb;
  logic [MW:0]        trial;
  logic [MW-1:0]      dividend, rem_sh;
  logic signed [PW:0] nsum, dsum;
  logic [MW-1:0]      diff;

  logic signed [NUM_W-1:0] rnum, rnum_next;
  logic [DEN_W-1:0]   rden, rden_next;
  logic [1:0]         rord, rord_next;
  logic               rerr, rerr_next;
  logic               ovalid, ovalid_next;
  logic [MW-1:0]      res_num_mag, res_num_mag_next;

  logic signed [NUM_W-1:0] onum;
  logic [DEN_W-1:0]   oden;
  logic [1:0]         oord;
  logic               oerr;

  logic signed [IW-1:0] a_num_w, a_den_w, b_num_w, b_den_w;
  assign a_num_w = IW'($unsigned(a_num));
  assign a_den_w = IW'($unsigned(a_den));
  assign b_num_w = IW'($unsigned(b_num));
  assign b_den_w = IW'($unsigned(b_den));

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = ovalid;
  assign result_num = onum;
  assign result_den = oden;
  assign order      = oord;
  assign error      = oerr;

  always_comb begin
    case (state)
      S_MUL1: begin
        ma = an;
        mb = (cmd == CMD_MUL) ? bn : bd;
      end
      S_MUL2: begin
        ma = ad;
        mb = (cmd == CMD_DIV) ? bn : bd;
      end
      default: begin
        ma = bn;
        mb = ad;
      end
    endcase
  end
  assign prod = PW'(ma * mb);

  assign nsum = (cmd == CMD_ADD) ? ((PW+1)'(p1) + (PW+1)'(prod))
                                 : ((PW+1)'(p1) - (PW+1)'(prod));
  assign diff = (u > v) ? (u - v) : (v - u);
  assign dividend = (state == S_DIVN) ? mn : md;
  assign rem_sh = {rem[MW-2:0], dividend[MW-1 - cnt[CW-2:0]]};
  assign trial = {1'b0, rem_sh} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
    if (state == S_IDLE && in_valid && in_ready) begin
      cmd <= command;
      an  <= a_num_w[OB-1:0];
      ad  <= a_den_w[OB-1:0];
      bn  <= b_num_w[OB-1:0];
      bd  <= b_den_w[OB-1:0];
    end
    if (state == S_MUL1) p1 <= prod;
    if (state == S_MUL2) p2 <= prod;
    if (state == S_DONE && (!ovalid || out_ready)) begin
      onum <= rnum;
      oden <= rden;
      oord <= rord;
      oerr <= rerr;
    end
    neg <= neg_next;
    mn <= mn_next; md <= md_next; u <= u_next; v <= v_next;
    q <= q_next; rem <= rem_next; g <= g_next;
    cnt <= cnt_next; sh <= sh_next;
    rnum <= rnum_next; rden <= rden_next; rord <= rord_next; rerr <= rerr_next;
    res_num_mag <= res_num_mag_next;
  end

  always_comb begin
    state_next = state;
    ovalid_next = ovalid;
    neg_next = neg;
    mn_next = mn; md_next = md; u_next = u; v_next = v;
    q_next = q; rem_next = rem; g_next = g;
    cnt_next = cnt; sh_next = sh;
    rnum_next = rnum; rden_next = rden; rord_next = rord; rerr_next = rerr;
    res_num_mag_next = res_num_mag;
    dsum = '0;
    if (ovalid && out_ready) ovalid_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) state_next = S_MUL1;
      end
      S_MUL1: begin
        rnum_next = '0; rden_next = '0; rord_next = ORD_LESS; rerr_next = 1'b0;
        if (cmd > CMD_CMP) begin
          state_next = S_DONE;
        end else if (ad == '0 || bd == '0 || (cmd == CMD_DIV && bn == '0)) begin
          rerr_next = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        if (cmd == CMD_MUL || cmd == CMD_DIV) dsum = (PW+1)'(p1);
        else dsum = nsum;
        neg_next = (dsum < 0) != (p2 < 0);
        mn_next = (dsum < 0) ? MW'(-dsum) : MW'(dsum);
        md_next = (p2 < 0) ? MW'(-(PW+1)'(p2)) : MW'((PW+1)'(p2));
        u_next = mn_next;
        v_next = md_next;
        sh_next = '0;
        if (mn_next == '0) begin
          rnum_next = '0; rden_next = DEN_W'(1); rord_next = ORD_EQUAL;
          state_next = S_DONE;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (u == v) begin
          g_next = u << sh;
          cnt_next = '0; rem_next = '0; q_next = '0;
          state_next = S_DIVN;
        end else if (!u[0] && !v[0]) begin
          u_next = u >> 1; v_next = v >> 1; sh_next = sh + 1'b1;
        end else if (!u[0]) begin
          u_next = u >> 1;
        end else if (!v[0]) begin
          v_next = v >> 1;
        end else if (u > v) begin
          u_next = diff >> 1;
        end else begin
          v_next = diff >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        if (trial[MW]) begin
          rem_next = rem_sh;
          q_next = {q[MW-2:0], 1'b0};
        end else begin
          rem_next = trial[MW-1:0];
          q_next = {q[MW-2:0], 1'b1};
        end
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(MW - 1)) begin
          cnt_next = '0;
          rem_next = '0;
          if (state == S_DIVN) begin
            res_num_mag_next = q_next;
            state_next = S_DIVD;
          end else begin
            rnum_next = neg ? NUM_W'(-{1'b0, res_num_mag}) : NUM_W'({1'b0, res_num_mag});
            rden_next = DEN_W'(q_next);
            rord_next = neg ? ORD_LESS : ORD_GREATER;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!ovalid || out_ready) begin
          ovalid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- design/rau_checker.sv -----
// Port-level checker for the rational arithmetic unit, bound to the top level.
module rau_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [30:0] result_den,
  input logic [1:0] order,
  input logic       error
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_den) && $stable(order) &&
    $stable(error)) else $error("result changed while waiting");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> result_den == '0 && order == 2'd0) else $error("error fields");
  a_ord: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> order != 2'd3) else $error("bad order");
endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result_den(result_den),
  .order(order), .error(error)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the rational arithmetic unit: directed and random fractions.
module tb_top
  import rau_pkg::*;
();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] command = 3'd0;
  logic signed [15:0] a_num = '0, a_den = 16'sd1, b_num = '0, b_den = 16'sd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NUM_W-1:0] result_num;
  logic [DEN_W-1:0] result_den;
  logic [1:0] order;
  logic error;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [1:0] ord;
    logic err;
  } fraction_t;

  fraction_t pending_fractions[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;

  rational_arithmetic_unit_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready), .result_num(result_num),
    .result_den(result_den), .order(order), .error(error)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduced_fraction(logic [2:0] cmd, logic signed [15:0] an,
                                                 logic signed [15:0] ad, logic signed [15:0] bn,
                                                 logic signed [15:0] bd);
    fraction_t f;
    longint n, d;
    longint unsigned mn, md, g;
    logic neg;
    f = '0;
    if (cmd > CMD_CMP) return f;
    if (ad == 0 || bd == 0 || (cmd == CMD_DIV && bn == 0)) begin
      f.err = 1'b1;
      return f;
    end
    case (cmd)
      CMD_ADD: begin
        n = longint'(an) * bd + longint'(bn) * ad;
        d = longint'(ad) * bd;
      end
      CMD_MUL: begin
        n = longint'(an) * bn;
        d = longint'(ad) * bd;
      end
      CMD_DIV: begin
        n = longint'(an) * bd;
        d = longint'(ad) * bn;
      end
      default: begin
        n = longint'(an) * bd - longint'(bn) * ad;
        d = longint'(ad) * bd;
      end
    endcase
    neg = (n < 0) != (d < 0);
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    if (mn == 0) begin
      f.den = DEN_W'(1);
      f.ord = ORD_EQUAL;
      return f;
    end
    g = euclid(mn, md);
    mn = mn / g;
    md = md / g;
    f.num = neg ? NUM_W'(-mn) : NUM_W'(mn);
    f.den = DEN_W'(md);
    f.ord = neg ? ORD_LESS : ORD_GREATER;
    return f;
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    command <= cmd;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    in_valid <= 1'b1;
    pending_fractions.push_back(reduced_fraction(cmd, an, ad, bn, bd));
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    fraction_t exp_f, got;
    if (!rst && out_valid && out_ready) begin
      got = {result_num, result_den, order, error};
      results_seen++;
      if (pending_fractions.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result %h", $time, got);
      end else begin
        exp_f = pending_fractions.pop_front();
        if (got.num !== exp_f.num || got.den !== exp_f.den || got.ord !== exp_f.ord ||
            got.err !== exp_f.err) begin
          mismatches++;
          $display("%0t mismatch: expected num %0d den %0d order %0d error %0d,",
                   $time, $signed(exp_f.num), exp_f.den, exp_f.ord, exp_f.err);
          $display("  got num %0d den %0d order %0d error %0d",
                   $signed(got.num), got.den, got.ord, got.err);
        end
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [15:0] random_operand();
    case ($urandom_range(5))
      0: return 16'(16'h8000 + $urandom_range(2));
      1: return 16'(16'h7fff - $urandom_range(2));
      2: return 16'($urandom_range(8) - 4);
      3: return 16'($urandom_range(64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [2:0] c;
    for (int i = 0; i < 5; i++) begin
      c = 3'(i);
      send_item(c, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    end
    send_item(CMD_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
    send_item(CMD_SUB, 16'd1, 16'd1, 16'd1, 16'd0);
    send_item(CMD_DIV, 16'd3, 16'd4, 16'd0, 16'd7);
    send_item(CMD_CMP, 16'd2, 16'd4, 16'd1, 16'd2);
    send_item(CMD_CMP, -16'sd3, 16'd4, 16'd1, 16'd2);
    send_item(CMD_CMP, 16'd3, -16'sd4, -16'sd1, 16'd2);
    send_item(CMD_ADD, -16'sd6, 16'd4, 16'd0, -16'sd9);
    send_item(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
    send_item(CMD_DIV, 16'h8000, 16'hffff, 16'hffff, 16'h8000);
    send_item(CMD_SUB, 16'h8000, 16'd1, 16'h7fff, 16'h8000);
    send_item(3'd5, 16'd1, 16'd1, 16'd1, 16'd1);
    send_item(3'd6, 16'd1, 16'd0, 16'd1, 16'd1);
    send_item(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
    logic [2:0] c;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      c = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_item(c, random_operand(), random_operand(), random_operand(), random_operand());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(480, 74, 0);
    test_random(480, 0, 74);
    test_random(480, 17, 17);
    in_valid <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items over all commands, error cases and idle mixes; checked %0d results.",
             items_sent, results_seen);
    if (mismatches == 0 && pending_fractions.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Timed out with %0d results outstanding.", pending_fractions.size());
    $display("status: fail");
    $finish;
  end
endmodule

// ----- rational_arithmetic_unit_top.f -----
design/rau_pkg.sv
design/rational_arithmetic_unit_top.sv
design/rau_checker.sv
bench/tb_top.sv
